// File: hw/rtl/tss_pkg.sv
// Package for the thread slot scheduler: word types, event, policy,
// slot state and sequencer codes, default sizes. No dependencies.
package tss_pkg;

   localparam int THREAD_SLOTS_DEF = 16;
   localparam int TIME_BITS_DEF    = 32;

   typedef enum logic [1:0] {
      MODE_CREATE   = 2'd0,
      MODE_YIELD    = 2'd1,
      MODE_EXIT     = 2'd2,
      MODE_SCHEDULE = 2'd3
   } mode_type;

   localparam logic [1:0] POLICY_RR   = 2'd0;
   localparam logic [1:0] POLICY_PRIO = 2'd1;
   localparam logic [1:0] POLICY_FCFS = 2'd2;

   typedef enum logic [1:0] {
      SLOT_FREE     = 2'd0,
      SLOT_RUNNABLE = 2'd1,
      SLOT_YIELDED  = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      SEQ_IDLE  = 2'd0,
      SEQ_SCAN  = 2'd1,
      SEQ_DRAIN = 2'd2,
      SEQ_DONE  = 2'd3
   } seq_state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  priority_req;
      logic [31:0] now_time;
   } req_word_type;

   typedef struct packed {
      logic       accepted;
      logic [3:0] thread_id;
      logic       idle;
   } rsp_word_type;

endpackage

// File: hw/rtl/thread_slot_scheduler_core.sv
// Thread slot scheduler top level: slot table, scan sequencer and shared
// comparator. Depends on tss_pkg.
//
// Usage: present a request word with start while busy is low; the event is
// taken at that edge. Create and schedule walk the whole slot table, one
// slot per cycle through a single magnitude comparator fed from the
// priority and creation-time memories, so busy stays high through the
// scan of every slot, a drain state for the registered memory read and a
// done state that updates the table. Yield and exit touch only the
// running slot and go straight from idle to the done state.
// Every event gives exactly one response word, shown for one cycle with
// rsp_valid in the cycle busy falls; the receiver cannot stall it, so
// capture it then. The policy register may be written through the csr
// channel (always ready) while no event is in flight. Slot 0 belongs to
// the scheduler and is never created or chosen. Reset clears the slot
// states at once; no clearing pass is needed.
module thread_slot_scheduler_core
   import tss_pkg::*;
#(
   parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
   parameter int TIME_BITS    = TIME_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_data,
   output logic         rsp_valid,
   output rsp_word_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_data
);

   localparam int IDX_W = $clog2(THREAD_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(THREAD_SLOTS - 1);
   localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

   // sequencer and captured event
   seq_state_type     state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [7:0]        pri_ff, pri_in;
   logic [TIME_BITS-1:0] now_ff, now_in;

   // scan issue stage
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]  scan_cnt_ff, scan_cnt_in;

   // compare stage (lines up with registered memory read)
   logic              s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]  s1_idx_ff, s1_idx_in;
   slot_state_type    s1_state_ff, s1_state_in;
   logic [7:0]        rd_pri_ff;
   logic [TIME_BITS-1:0] rd_time_ff;

   // best candidate so far
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   logic [TIME_BITS-1:0] best_key_ff, best_key_in;

   // architectural state
   slot_state_type    slot_state_ff [THREAD_SLOTS];
   slot_state_type    slot_state_in [THREAD_SLOTS];
   logic [IDX_W-1:0]  running_ff, running_in;
   logic [IDX_W-1:0]  yielded_ff, yielded_in;
   logic [1:0]        policy_ff, policy_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_ff, rsp_in;

   // priority / creation time memories, no reset (read only once written)
   logic [7:0]           pri_mem  [THREAD_SLOTS];
   logic [TIME_BITS-1:0] time_mem [THREAD_SLOTS];
   logic                 mem_we;

   // helpers
   logic [TIME_BITS+31:0] now_wide;
   logic [TIME_BITS-1:0]  now_ext;
   logic [TIME_BITS-1:0]  cmp_a, cmp_b;
   logic                  cmp_gt;
   logic                  take;
   logic                  use_prio;
   logic                  use_rr;
   logic [IDX_W+3:0]      tid_wide;
   logic                  y_ok;
   logic [IDX_W-1:0]      next_id;

   assign now_wide  = {{TIME_BITS{1'b0}}, req_data.now_time};
   assign now_ext   = now_wide[TIME_BITS-1:0];
   assign use_prio  = (policy_ff == POLICY_PRIO);
   assign use_rr    = (policy_ff == POLICY_RR);

   // shared comparator: priority wants new > best, FCFS wants limit > created
   always_comb begin
      if (use_prio) begin
         cmp_a = TIME_BITS'(rd_pri_ff);
         cmp_b = best_key_ff;
      end else begin
         cmp_a = best_key_ff;
         cmp_b = rd_time_ff;
      end
   end
   assign cmp_gt = (cmp_a > cmp_b);

   always_comb begin
      take = 1'b0;
      if (s1_valid_ff && (s1_idx_ff != '0)) begin
         if (mode_ff == MODE_CREATE) begin
            take = (s1_state_ff == SLOT_FREE) && !found_ff;
         end else begin
            case (policy_ff)
               POLICY_RR: begin
                  take = (s1_state_ff == SLOT_RUNNABLE) && !found_ff;
               end
               POLICY_PRIO: begin
                  take = (s1_state_ff == SLOT_RUNNABLE) && (!found_ff || cmp_gt);
               end
               default: begin
                  // FCFS, also the unused policy code
                  take = (s1_state_ff == SLOT_RUNNABLE) && cmp_gt;
               end
            endcase
         end
      end
   end

   assign y_ok     = (slot_state_ff[yielded_ff] == SLOT_YIELDED);
   assign next_id  = found_ff ? best_ff : yielded_ff;

   // sequencer: next state and datapath control
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      pri_in      = pri_ff;
      now_in      = now_ff;
      scan_idx_in = scan_idx_ff;
      scan_cnt_in = scan_cnt_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      best_key_in = best_key_ff;
      slot_state_in = slot_state_ff;
      running_in  = running_ff;
      yielded_in  = yielded_ff;
      policy_in   = policy_ff;
      rsp_valid_in = 1'b0;
      rsp_in      = rsp_ff;
      mem_we      = 1'b0;
      tid_wide    = '0;

      s1_valid_in = (state_ff == SEQ_SCAN);
      s1_idx_in   = scan_idx_ff;
      s1_state_in = slot_state_ff[scan_idx_ff];

      if (csr_valid) begin
         policy_in = csr_data;
      end

      if (take) begin
         found_in    = 1'b1;
         best_in     = s1_idx_ff;
         best_key_in = use_prio ? TIME_BITS'(rd_pri_ff) : rd_time_ff;
      end

      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               mode_in     = mode_type'(req_data.mode);
               pri_in      = req_data.priority_req;
               now_in      = now_ext;
               found_in    = 1'b0;
               best_in     = '0;
               best_key_in = now_ext;
               scan_cnt_in = '0;
               if (req_data.mode == MODE_SCHEDULE && use_rr) begin
                  scan_idx_in = (running_ff == LAST_IDX) ? '0 : running_ff + 1'b1;
               end else begin
                  scan_idx_in = FIRST_IDX;
               end
               if (req_data.mode == MODE_CREATE || req_data.mode == MODE_SCHEDULE) begin
                  state_in = SEQ_SCAN;
               end else begin
                  state_in = SEQ_DONE;
               end
            end
         end
         SEQ_SCAN: begin
            scan_idx_in = (scan_idx_ff == LAST_IDX) ? '0 : scan_idx_ff + 1'b1;
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == LAST_IDX) begin
               state_in = SEQ_DRAIN;
            end
         end
         SEQ_DRAIN: begin
            state_in = SEQ_DONE;
         end
         SEQ_DONE: begin
            state_in     = SEQ_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            case (mode_ff)
               MODE_CREATE: begin
                  if (found_ff) begin
                     slot_state_in[best_ff] = SLOT_RUNNABLE;
                     mem_we                 = 1'b1;
                     tid_wide               = {4'b0, best_ff};
                     rsp_in.accepted        = 1'b1;
                     rsp_in.thread_id       = tid_wide[3:0];
                  end
               end
               MODE_YIELD: begin
                  if (running_ff != '0 && slot_state_ff[running_ff] != SLOT_FREE) begin
                     slot_state_in[running_ff] = SLOT_YIELDED;
                     yielded_in                = running_ff;
                  end
               end
               MODE_EXIT: begin
                  if (running_ff != '0 && slot_state_ff[running_ff] != SLOT_FREE) begin
                     slot_state_in[running_ff] = SLOT_FREE;
                  end
               end
               default: begin
                  // schedule; fall back to the yielded thread
                  if (!found_ff && !y_ok) begin
                     rsp_in.idle = 1'b1;
                  end else begin
                     if (y_ok) begin
                        slot_state_in[yielded_ff] = SLOT_RUNNABLE;
                     end
                     running_in       = next_id;
                     tid_wide         = {4'b0, next_id};
                     rsp_in.accepted  = 1'b1;
                     rsp_in.thread_id = tid_wide[3:0];
                  end
               end
            endcase
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         s1_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         running_ff   <= '0;
         yielded_ff   <= '0;
         policy_ff    <= POLICY_RR;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < THREAD_SLOTS; i++) begin
            slot_state_ff[i] <= SLOT_FREE;
         end
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         found_ff     <= found_in;
         running_ff   <= running_in;
         yielded_ff   <= yielded_in;
         policy_ff    <= policy_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_state_ff <= slot_state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      pri_ff      <= pri_in;
      now_ff      <= now_in;
      scan_idx_ff <= scan_idx_in;
      scan_cnt_ff <= scan_cnt_in;
      s1_idx_ff   <= s1_idx_in;
      s1_state_ff <= s1_state_in;
      best_ff     <= best_in;
      best_key_ff <= best_key_in;
      rsp_ff      <= rsp_in;
   end

   // slot memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pri_mem[best_ff]  <= pri_ff;
         time_mem[best_ff] <= now_ff;
      end
      rd_pri_ff  <= pri_mem[scan_idx_ff];
      rd_time_ff <= time_mem[scan_idx_ff];
   end

   assign busy      = (state_ff != SEQ_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule
